/* hw/rtl/demand_paging_frame_manager_core_macros.svh */
// Assertion helpers for the frame manager. They expect clk and arst_n in scope.
`ifndef DEMAND_PAGING_FRAME_MANAGER_CORE_MACROS_SVH
`define DEMAND_PAGING_FRAME_MANAGER_CORE_MACROS_SVH

// Same-cycle implication.
`define DPFM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dpfm assertion failed");

// Next-cycle implication.
`define DPFM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dpfm assertion failed");

`endif

/* hw/rtl/dpfm_pkg.sv */
package dpfm_pkg;

	// default sizing
	localparam int NUM_FRAMES_DEF = 64;
	localparam int MAX_PROCS_DEF  = 16;
	localparam int MAX_PAGES_DEF  = 64;

	// per-page age counter
	localparam int AGE_W = 16;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int CFG_W   = 7;
	localparam logic [0:0] REG_MAX_FRAMES   = 1'b0;
	localparam logic [0:0] REG_FRAMES_INUSE = 1'b1;
	localparam logic [CFG_W-1:0] MAX_FRAMES_RST   = 7'd4;
	localparam logic [CFG_W-1:0] FRAMES_INUSE_RST = 7'd64;

	// request opcodes
	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_READ   = 2'd1,
		OP_WRITE  = 2'd2,
		OP_FINISH = 2'd3
	} opcode_t;

	// response status codes
	localparam logic [2:0] STS_OK       = 3'd0;
	localparam logic [2:0] STS_UNKNOWN  = 3'd1;
	localparam logic [2:0] STS_RANGE    = 3'd2;
	localparam logic [2:0] STS_NO_FRAME = 3'd3;
	localparam logic [2:0] STS_ACTIVE   = 3'd4;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] process_id;
		logic [5:0] page_number;
		logic [6:0] page_count;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] frame_number;
		logic       page_fault;
		logic       fetch_from_swap;
		logic       victim_valid;
		logic [5:0] victim_page;
		logic       write_back;
	} rsp_t;

	typedef struct packed {
		logic [CFG_W-1:0] max_frames_per_process;
		logic [CFG_W-1:0] frames_in_use;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CLEAR,
		ST_FINISH,
		ST_ACCESS,
		ST_FSCAN,
		ST_WR_VIC,
		ST_WR_LOAD,
		ST_RESP
	} state_t;

endpackage

/* hw/rtl/dpfm_apb_regs.sv */
module dpfm_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dpfm_pkg::PADDR_W-1:0]  paddr,
	input  logic [dpfm_pkg::PDATA_W-1:0]  pwdata,
	output logic [dpfm_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output dpfm_pkg::cfg_t                cfg
);

	logic [dpfm_pkg::CFG_W-1:0] max_frames_q;
	logic [dpfm_pkg::CFG_W-1:0] frames_inuse_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// register writes, word address in paddr[2]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frames_q   <= dpfm_pkg::MAX_FRAMES_RST;
			frames_inuse_q <= dpfm_pkg::FRAMES_INUSE_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				dpfm_pkg::REG_MAX_FRAMES:   max_frames_q   <= pwdata[dpfm_pkg::CFG_W-1:0];
				dpfm_pkg::REG_FRAMES_INUSE: frames_inuse_q <= pwdata[dpfm_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			dpfm_pkg::REG_MAX_FRAMES:   prdata = dpfm_pkg::PDATA_W'(max_frames_q);
			dpfm_pkg::REG_FRAMES_INUSE: prdata = dpfm_pkg::PDATA_W'(frames_inuse_q);
			default:                    prdata = '0;
		endcase
	end

	assign cfg.max_frames_per_process = max_frames_q;
	assign cfg.frames_in_use          = frames_inuse_q;

endmodule

/* hw/rtl/dpfm_page_ram.sv */
module dpfm_page_ram #(
	parameter int AW = 10,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	localparam int DEPTH = 1 << AW;

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/demand_paging_frame_manager_core.sv */
// Demand-paging frame manager with per-process local FIFO replacement.
// Requests arrive on req (valid/ready) and each one yields exactly one
// response on rsp (valid/ready). Two configuration registers sit on the APB
// port: max frames per process at 0x0, frames in use at 0x4; pready is tied high.
// The block works on one request at a time; req_ready is high only while idle.
// Work per request (lim = process page count):
//   status-only errors: decode only
//   start: clears the present bits of the process's pages
//   finish: frees frames while clearing
//   access: sweeps lim entries to age pages and find a hit; a fault also searches
//   for a free frame and evicts a present page when none is free or the limit is hit
// The next request can be taken as soon as its predecessor's response turns valid.
// Request time goes to the page-table RAM, swept one entry per cycle for aging and
// victim choice, and to the free-frame search, one frame per cycle.
// Reset clears process slots, page limits and the frame busy map at once;
// page-table RAM rows are cleared by start, so no clearing pass runs.
// A finished response sits in an output register; when the receiver stalls
// the block still takes the next request and holds its result until
// the output register empties.
module demand_paging_frame_manager_core #(
	parameter int NUM_FRAMES = dpfm_pkg::NUM_FRAMES_DEF,
	parameter int MAX_PROCS  = dpfm_pkg::MAX_PROCS_DEF,
	parameter int MAX_PAGES  = dpfm_pkg::MAX_PAGES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  dpfm_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output dpfm_pkg::rsp_t               rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dpfm_pkg::PADDR_W-1:0] paddr,
	input  logic [dpfm_pkg::PDATA_W-1:0] pwdata,
	output logic [dpfm_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

`include "demand_paging_frame_manager_core_macros.svh"

	localparam int PIW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int LW    = $clog2(MAX_PAGES + 1);
	localparam int FW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int FCW   = $clog2(NUM_FRAMES + 1);
	localparam int AGE_W = dpfm_pkg::AGE_W;
	localparam int AW    = PIW + PW;
	localparam int EW    = 2 + FW + AGE_W;
	localparam int RSP_W = $bits(dpfm_pkg::rsp_t);

	dpfm_pkg::cfg_t   cfg;
	dpfm_pkg::state_t state_q, state_d, dec_next;

	dpfm_pkg::req_t   req_q;
	dpfm_pkg::rsp_t   res_q, rsp_q;
	logic             rsp_valid_q;

	logic [MAX_PROCS-1:0] active_q;
	logic [LW-1:0]        plim_q [MAX_PROCS];
	logic [NUM_FRAMES-1:0] frame_busy_q;

	// sweep and scan state
	logic [LW-1:0]    lim_q, pcnt_q, cnt_q;
	logic             pend_s1;
	logic [PW-1:0]    page_s1;
	logic             hit_q;
	logic [FW-1:0]    hit_frame_q;
	logic             vic_have_q, vic_dirty_q;
	logic [AGE_W-1:0] vic_age_q;
	logic [PW-1:0]    vic_page_q;
	logic [FW-1:0]    vic_frame_q;
	logic [FCW-1:0]   fcnt_q, nf;
	logic [FW-1:0]    new_frame_q, fidx;

	// ram
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	// decode helpers
	logic [PIW-1:0]   pid_idx;
	logic [PW-1:0]    pg_idx;
	logic             pid_ok, act, is_write;
	logic [LW-1:0]    plim;
	logic [2:0]       dec_status;
	logic             sweep_issue, sweep_done, cnt_lt_max, fs_free, fs_end;
	logic             e_present, e_dirty, e_take;
	logic [FW-1:0]    e_frame;
	logic [AGE_W-1:0] e_age, age_inc;

	dpfm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dpfm_page_ram #(
		.AW (AW),
		.DW (EW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req_ready = (state_q == dpfm_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// request fields
	assign pid_idx  = PIW'(req_q.process_id);
	assign pg_idx   = PW'(req_q.page_number);
	assign pid_ok   = 32'(req_q.process_id) < MAX_PROCS;
	assign act      = pid_ok && active_q[pid_idx];
	assign plim     = plim_q[pid_idx];
	assign is_write = (req_q.opcode == dpfm_pkg::OP_WRITE);

	// page-table entry read back from the ram
	assign e_present = ram_rdata[EW-1];
	assign e_dirty   = ram_rdata[EW-2];
	assign e_frame   = ram_rdata[AGE_W +: FW];
	assign e_age     = ram_rdata[AGE_W-1:0];
	assign age_inc   = (e_age == '1) ? e_age : e_age + AGE_W'(1);
	assign e_take    = e_present && (!vic_have_q || (e_age > vic_age_q));

	assign sweep_issue = pcnt_q < lim_q;
	assign sweep_done  = !sweep_issue && !pend_s1;
	assign cnt_lt_max  = 32'(cnt_q) < 32'(cfg.max_frames_per_process);

	// frame search bound and probe
	assign nf      = (32'(cfg.frames_in_use) > NUM_FRAMES) ? FCW'(NUM_FRAMES)
	                                                       : FCW'(cfg.frames_in_use);
	assign fidx    = fcnt_q[FW-1:0];
	assign fs_end  = (fcnt_q == nf);
	assign fs_free = !fs_end && !frame_busy_q[fidx];

	// request decode and early errors
	always_comb begin
		dec_status = dpfm_pkg::STS_OK;
		dec_next   = dpfm_pkg::ST_RESP;
		if (!pid_ok) begin
			dec_status = dpfm_pkg::STS_UNKNOWN;
		end else if (req_q.opcode == dpfm_pkg::OP_START) begin
			if (act) begin
				dec_status = dpfm_pkg::STS_ACTIVE;
			end else if (32'(req_q.page_count) > MAX_PAGES) begin
				dec_status = dpfm_pkg::STS_RANGE;
			end else begin
				dec_next = dpfm_pkg::ST_CLEAR;
			end
		end else if (!act) begin
			dec_status = dpfm_pkg::STS_UNKNOWN;
		end else if (req_q.opcode == dpfm_pkg::OP_FINISH) begin
			dec_next = dpfm_pkg::ST_FINISH;
		end else if (32'(req_q.page_number) >= 32'(plim)) begin
			dec_status = dpfm_pkg::STS_RANGE;
		end else begin
			dec_next = dpfm_pkg::ST_ACCESS;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpfm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and ram control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = {pid_idx, page_s1};
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = {pid_idx, pcnt_q[PW-1:0]};
		unique case (state_q)
			dpfm_pkg::ST_IDLE: begin
				if (req_valid) state_d = dpfm_pkg::ST_DECODE;
			end
			dpfm_pkg::ST_DECODE: begin
				state_d = dec_next;
			end
			dpfm_pkg::ST_CLEAR: begin
				if (sweep_issue) begin
					ram_we    = 1'b1;
					ram_waddr = {pid_idx, pcnt_q[PW-1:0]};
				end else begin
					state_d = dpfm_pkg::ST_RESP;
				end
			end
			dpfm_pkg::ST_FINISH: begin
				ram_re = sweep_issue;
				ram_we = pend_s1;
				if (sweep_done) state_d = dpfm_pkg::ST_RESP;
			end
			dpfm_pkg::ST_ACCESS: begin
				ram_re = sweep_issue;
				// age every present page; a write hit also marks dirty
				if (pend_s1 && e_present) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b1, e_dirty | (is_write && (page_s1 == pg_idx)),
					             e_frame, age_inc};
				end
				if (sweep_done) begin
					if (hit_q) begin
						state_d = dpfm_pkg::ST_RESP;
					end else if (cnt_lt_max) begin
						state_d = dpfm_pkg::ST_FSCAN;
					end else if (cnt_q != '0) begin
						state_d = dpfm_pkg::ST_WR_VIC;
					end else begin
						state_d = dpfm_pkg::ST_RESP;
					end
				end
			end
			dpfm_pkg::ST_FSCAN: begin
				if (fs_end) begin
					state_d = (cnt_q != '0) ? dpfm_pkg::ST_WR_VIC : dpfm_pkg::ST_RESP;
				end else if (fs_free) begin
					state_d = dpfm_pkg::ST_WR_LOAD;
				end
			end
			dpfm_pkg::ST_WR_VIC: begin
				ram_we    = 1'b1;
				ram_waddr = {pid_idx, vic_page_q};
				state_d   = dpfm_pkg::ST_WR_LOAD;
			end
			dpfm_pkg::ST_WR_LOAD: begin
				// loaded page starts at age zero and is aged once with the rest
				ram_we    = 1'b1;
				ram_waddr = {pid_idx, pg_idx};
				ram_wdata = {1'b1, is_write, new_frame_q, AGE_W'(1)};
				state_d   = dpfm_pkg::ST_RESP;
			end
			dpfm_pkg::ST_RESP: begin
				if (!rsp_valid_q || rsp_ready) state_d = dpfm_pkg::ST_IDLE;
			end
			default: state_d = dpfm_pkg::ST_IDLE;
		endcase
	end

	// process slots, page limits, frame busy map, read pipeline flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= '0;
			frame_busy_q <= '0;
			pend_s1      <= 1'b0;
			for (int i = 0; i < MAX_PROCS; i++) begin
				plim_q[i] <= '0;
			end
		end else begin
			pend_s1 <= ram_re;
			if (state_q == dpfm_pkg::ST_DECODE) begin
				if (dec_next == dpfm_pkg::ST_CLEAR) begin
					active_q[pid_idx] <= 1'b1;
					plim_q[pid_idx]   <= LW'(req_q.page_count);
				end else if (dec_next == dpfm_pkg::ST_FINISH) begin
					active_q[pid_idx] <= 1'b0;
					plim_q[pid_idx]   <= '0;
				end
			end
			if ((state_q == dpfm_pkg::ST_FINISH) && pend_s1 && e_present &&
			    (32'(e_frame) < NUM_FRAMES)) begin
				frame_busy_q[e_frame] <= 1'b0;
			end
			if ((state_q == dpfm_pkg::ST_FSCAN) && fs_free) begin
				frame_busy_q[fidx] <= 1'b1;
			end
		end
	end

	// sweep datapath and result assembly
	always_ff @(posedge clk) begin
		if (state_q == dpfm_pkg::ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (ram_re || (state_q == dpfm_pkg::ST_CLEAR && sweep_issue)) begin
			pcnt_q <= pcnt_q + LW'(1);
		end
		if (ram_re) begin
			page_s1 <= pcnt_q[PW-1:0];
		end
		unique case (state_q)
			dpfm_pkg::ST_DECODE: begin
				res_q        <= dpfm_pkg::rsp_t'({dec_status, {(RSP_W-3){1'b0}}});
				pcnt_q       <= '0;
				cnt_q        <= '0;
				fcnt_q       <= '0;
				hit_q        <= 1'b0;
				vic_have_q   <= 1'b0;
				lim_q        <= (dec_next == dpfm_pkg::ST_ACCESS) ? plim : LW'(MAX_PAGES);
			end
			dpfm_pkg::ST_ACCESS: begin
				if (pend_s1 && e_present) begin
					cnt_q <= cnt_q + LW'(1);
					if (page_s1 == pg_idx) begin
						hit_q       <= 1'b1;
						hit_frame_q <= e_frame;
					end
				end
				// oldest present page, lowest page number on a tie
				if (pend_s1 && e_take) begin
					vic_have_q  <= 1'b1;
					vic_age_q   <= e_age;
					vic_page_q  <= page_s1;
					vic_frame_q <= e_frame;
					vic_dirty_q <= e_dirty;
				end
				if (sweep_done) begin
					if (hit_q) begin
						res_q.frame_number <= 6'(hit_frame_q);
					end else if (!cnt_lt_max && cnt_q == '0) begin
						res_q.status <= dpfm_pkg::STS_NO_FRAME;
					end
				end
			end
			dpfm_pkg::ST_FSCAN: begin
				if (fs_end) begin
					if (cnt_q == '0) res_q.status <= dpfm_pkg::STS_NO_FRAME;
				end else if (fs_free) begin
					new_frame_q <= fidx;
				end else begin
					fcnt_q <= fcnt_q + FCW'(1);
				end
			end
			dpfm_pkg::ST_WR_VIC: begin
				new_frame_q        <= vic_frame_q;
				res_q.victim_valid <= 1'b1;
				res_q.victim_page  <= 6'(vic_page_q);
				res_q.write_back   <= vic_dirty_q;
			end
			dpfm_pkg::ST_WR_LOAD: begin
				res_q.frame_number    <= 6'(new_frame_q);
				res_q.page_fault      <= 1'b1;
				res_q.fetch_from_swap <= !is_write;
			end
			dpfm_pkg::ST_RESP: begin
				if (!rsp_valid_q || rsp_ready) rsp_q <= res_q;
			end
			default: ;
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == dpfm_pkg::ST_RESP && (!rsp_valid_q || rsp_ready)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	`DPFM_ASSERT_NXT(a_accept_decodes, req_valid && req_ready, state_q == dpfm_pkg::ST_DECODE)
	`DPFM_ASSERT_IMP(a_load_frame_busy, state_q == dpfm_pkg::ST_WR_LOAD, frame_busy_q[new_frame_q])
	`DPFM_ASSERT_IMP(a_sweep_bound, state_q == dpfm_pkg::ST_ACCESS, pcnt_q <= lim_q)
	`DPFM_ASSERT_IMP(a_rsp_from_resp, $rose(rsp_valid_q), $past(state_q) == dpfm_pkg::ST_RESP)

endmodule
